// File: rtl/pnrre_pkg.sv
// Package for the packed nibble rectangle raster engine.
// Holds beat types, command codes, controller states and geometry constants.
// No dependencies.
package pnrre_pkg;

   localparam int RowBytes = 512;
   localparam int RowCount = 512;
   localparam int ColW = 10;
   localparam int RowW = 9;
   localparam int ByteW = 9;
   localparam int AddrW = RowW + ByteW;

   typedef enum logic [2:0] {
      CMD_POINT = 3'd0,
      CMD_OUTLINE = 3'd1,
      CMD_CLR_OUTLINE = 3'd2,
      CMD_CLR_FILL = 3'd3,
      CMD_DOTTED = 3'd4,
      CMD_CLR_ROWS = 3'd5,
      CMD_READ = 3'd6,
      CMD_NONE = 3'd7
   } cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [ColW-1:0] x_start;
      logic [RowW-1:0] y_start;
      logic [ColW-1:0] x_end;
      logic [RowW-1:0] y_end;
      logic [3:0] color;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_RESULT
   } state_type;

   // One byte operation issued by the controller to the datapath.
   typedef struct packed {
      logic rd;
      logic wr;
      logic [AddrW-1:0] addr;
      logic [7:0] and_mask;
      logic [7:0] or_val;
   } dp_cmd_type;

endpackage

// File: rtl/pnrre_datapath.sv
// Datapath of the raster engine: frame store and read-modify-write byte unit.
// Depends on pnrre_pkg.
module pnrre_datapath (
   input  logic clock,
   input  pnrre_pkg::dp_cmd_type dp_cmd,
   output logic [7:0] rd_data
);

   logic [7:0] store_mem [0:pnrre_pkg::RowBytes*pnrre_pkg::RowCount-1];
   logic [7:0] rd_data_ff;
   logic [pnrre_pkg::AddrW-1:0] addr_ff;
   logic [7:0] and_ff;
   logic [7:0] or_ff;

   // Read first, then write the masked byte on the following cycle.
   always_ff @(posedge clock) begin
      if (dp_cmd.rd) begin
         rd_data_ff <= store_mem[dp_cmd.addr];
         addr_ff <= dp_cmd.addr;
         and_ff <= dp_cmd.and_mask;
         or_ff <= dp_cmd.or_val;
      end
      if (dp_cmd.wr) begin
         store_mem[addr_ff] <= (rd_data_ff & and_ff) | or_ff;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/pnrre_controller.sv
// Controller of the raster engine: validates commands and walks byte addresses.
// Depends on pnrre_pkg.
module pnrre_controller (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  pnrre_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output pnrre_pkg::rsp_type rsp_data,
   output pnrre_pkg::dp_cmd_type dp_cmd,
   input  logic [7:0] rd_data
);

   // Walk step kinds for the shape walks.
   localparam logic [2:0] PH_TOP = 3'd0;
   localparam logic [2:0] PH_BOT = 3'd1;
   localparam logic [2:0] PH_SIDE_L = 3'd2;
   localparam logic [2:0] PH_SIDE_R = 3'd3;

   pnrre_pkg::state_type state_ff, state_in;
   pnrre_pkg::req_type req_ff, req_in;
   logic [2:0] phase_ff, phase_in;
   logic [10:0] col_ff, col_in;
   logic [8:0] row_ff, row_in;
   logic rsp_valid_ff, rsp_valid_in;
   pnrre_pkg::rsp_type rsp_ff, rsp_in;
   logic is_read_ff, is_read_in;

   logic xs_ok, xe_ok, ys_ok, ye_ok, box_ok, bad;
   logic [3:0] c;
   logic [7:0] amask, oval;
   logic do_op, last;
   logic [10:0] x_op;
   logic [8:0] y_op;
   logic [9:0] e_even;
   logic [2:0] nph;
   logic [10:0] ncol;
   logic [8:0] nrow;

   always_comb begin
      xs_ok = 1'b1;
      xe_ok = 1'b1;
      ys_ok = 1'b1;
      ye_ok = 1'b1;
      box_ok = (req_data.x_start <= req_data.x_end) && (req_data.y_start <= req_data.y_end);
      case (pnrre_pkg::cmd_type'(req_data.cmd))
         pnrre_pkg::CMD_OUTLINE, pnrre_pkg::CMD_CLR_OUTLINE,
         pnrre_pkg::CMD_CLR_FILL: bad = !(xs_ok && xe_ok && ys_ok && ye_ok && box_ok);
         pnrre_pkg::CMD_DOTTED: bad = !(req_data.x_start <= req_data.x_end);
         pnrre_pkg::CMD_CLR_ROWS: bad = !(req_data.y_start <= req_data.y_end);
         default: bad = 1'b0;
      endcase
   end

   // Current step: decide the byte op for (phase, col, row) of the held command.
   always_comb begin
      c = req_ff.color;
      e_even = {req_ff.x_end[9:1], 1'b0};
      do_op = 1'b1;
      amask = 8'hFF;
      oval = 8'h00;
      x_op = col_ff;
      y_op = row_ff;
      nph = phase_ff;
      ncol = col_ff;
      nrow = row_ff;
      last = 1'b0;
      case (pnrre_pkg::cmd_type'(req_ff.cmd))
         pnrre_pkg::CMD_POINT: begin
            oval = req_ff.x_start[0] ? {4'h0, c} : {c, 4'h0};
            last = 1'b1;
         end
         pnrre_pkg::CMD_DOTTED: begin
            do_op = col_ff < {1'b0, req_ff.x_end};
            amask = 8'hF0;
            oval = {c, 4'h0};
            ncol = col_ff + 11'd2;
            last = !(ncol < {1'b0, req_ff.x_end});
         end
         pnrre_pkg::CMD_CLR_ROWS: begin
            amask = 8'h00;
            x_op = {col_ff[9:0], 1'b0};
            ncol = col_ff + 11'd1;
            if (col_ff == 11'(pnrre_pkg::RowBytes - 1)) begin
               ncol = '0;
               nrow = row_ff + 9'd1;
               last = (row_ff == req_ff.y_end);
            end
         end
         pnrre_pkg::CMD_CLR_FILL: begin
            // col_ff walks x from x_start by the file's steps.
            if (col_ff[0]) begin
               amask = 8'hF0;
               ncol = col_ff + 11'd1;
            end else if (col_ff < {1'b0, req_ff.x_end}) begin
               amask = 8'h00;
               ncol = col_ff + 11'd2;
            end else begin
               do_op = !req_ff.x_end[0];
               amask = 8'h0F;
               x_op = {1'b0, req_ff.x_end};
               ncol = 11'h7FF;
            end
            if (ncol == 11'h7FF || (!ncol[0] && !(ncol < {1'b0, req_ff.x_end})
                  && req_ff.x_end[0])) begin
               ncol = {1'b0, req_ff.x_start};
               nrow = row_ff + 9'd1;
               last = (row_ff == req_ff.y_end);
            end
         end
         pnrre_pkg::CMD_OUTLINE, pnrre_pkg::CMD_CLR_OUTLINE: begin
            if (phase_ff == PH_TOP || phase_ff == PH_BOT) begin
               y_op = (phase_ff == PH_TOP) ? req_ff.y_start : req_ff.y_end;
               if (col_ff[0] && col_ff == {1'b0, req_ff.x_start}) begin
                  amask = 8'hF0;
                  oval = {4'h0, c};
                  ncol = col_ff + 11'd1;
               end else if (col_ff < {1'b0, e_even}) begin
                  amask = 8'h00;
                  oval = {c, c};
                  ncol = col_ff + 11'd2;
               end else begin
                  amask = 8'h0F;
                  oval = {c, 4'h0};
                  do_op = (req_ff.cmd == pnrre_pkg::CMD_OUTLINE)
                     ? (col_ff < {1'b0, req_ff.x_end}) : !req_ff.x_end[0];
                  ncol = 11'h7FF;
               end
               if (ncol == 11'h7FF) begin
                  ncol = {1'b0, req_ff.x_start};
                  nph = (phase_ff == PH_TOP) ? PH_BOT : PH_SIDE_L;
                  nrow = req_ff.y_start;
               end
            end else begin
               x_op = (phase_ff == PH_SIDE_L) ? {1'b0, req_ff.x_start}
                                              : {1'b0, req_ff.x_end};
               amask = x_op[0] ? 8'hF0 : 8'h0F;
               oval = x_op[0] ? {4'h0, c} : {c, 4'h0};
               if (phase_ff == PH_SIDE_L) nph = PH_SIDE_R;
               else begin
                  nph = PH_SIDE_L;
                  nrow = row_ff + 9'd1;
                  last = (row_ff == req_ff.y_end);
               end
            end
            if (req_ff.cmd == pnrre_pkg::CMD_OUTLINE) amask = 8'hFF;
            else oval = 8'h00;
         end
         default: begin
            do_op = 1'b0;
            last = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      phase_in = phase_ff;
      col_in = col_ff;
      row_in = row_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      is_read_in = is_read_ff;
      req_stall = 1'b1;
      dp_cmd = '0;
      dp_cmd.addr = {y_op, x_op[9:1]};
      dp_cmd.and_mask = amask;
      dp_cmd.or_val = oval;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         pnrre_pkg::ST_IDLE: begin
            // The response register must drain before a new command may overwrite it.
            req_stall = rsp_valid_ff;
            if (req_valid && !rsp_valid_ff) begin
               req_in = req_data;
               phase_in = PH_TOP;
               col_in = (req_data.cmd == pnrre_pkg::CMD_CLR_ROWS) ? 11'd0
                                                                 : {1'b0, req_data.x_start};
               row_in = req_data.y_start;
               rsp_in = '0;
               rsp_in.error = bad;
               is_read_in = (req_data.cmd == pnrre_pkg::CMD_READ);
               if (bad || req_data.cmd == pnrre_pkg::CMD_NONE) state_in = pnrre_pkg::ST_RESULT;
               else if (req_data.cmd == pnrre_pkg::CMD_DOTTED
                        && req_data.x_start == req_data.x_end)
                  state_in = pnrre_pkg::ST_RESULT;
               else state_in = pnrre_pkg::ST_READ;
            end
         end
         pnrre_pkg::ST_READ: begin
            dp_cmd.rd = 1'b1;
            if (is_read_ff) begin
               dp_cmd.addr = {req_ff.y_start, req_ff.x_start[9:1]};
               state_in = pnrre_pkg::ST_RESULT;
            end else begin
               state_in = pnrre_pkg::ST_WRITE;
            end
         end
         pnrre_pkg::ST_WRITE: begin
            dp_cmd.wr = do_op;
            phase_in = nph;
            col_in = ncol;
            row_in = nrow;
            state_in = last ? pnrre_pkg::ST_RESULT : pnrre_pkg::ST_READ;
         end
         pnrre_pkg::ST_RESULT: begin
            if (is_read_ff) rsp_in.read_data = rd_data;
            if (!rsp_valid_in) begin
               rsp_valid_in = 1'b1;
               state_in = pnrre_pkg::ST_IDLE;
            end
         end
         default: state_in = pnrre_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pnrre_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff <= PH_TOP;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff <= phase_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      is_read_ff <= is_read_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// File: rtl/packed_nibble_rectangle_raster_engine_top.sv
// Top level of the packed nibble rectangle raster engine.
// Depends on pnrre_pkg, pnrre_controller and pnrre_datapath.

// The engine draws on a 4-bit-per-pixel framebuffer of 512 rows of 512 bytes, two
// pixels to a byte with the even column in the high nibble. One request beat holds
// one command; exactly one response beat follows it, carrying the byte read by a
// read command and an error flag for reversed coordinates, in which case nothing
// is drawn. Each byte touched is read and then written back on the single-port
// frame store. One command is in work at a time; a finished response waits in
// its register while the next request is held off. The store holds no reset
// value; read only bytes already drawn or cleared.
module packed_nibble_rectangle_raster_engine_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  pnrre_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output pnrre_pkg::rsp_type rsp_data
);

   pnrre_pkg::dp_cmd_type dp_cmd;
   logic [7:0] rd_data;

   // The controller walks the shape and issues byte operations.
   pnrre_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .dp_cmd(dp_cmd), .rd_data(rd_data)
   );

   // The datapath owns the frame store.
   pnrre_datapath u_dp (
      .clock(clock), .dp_cmd(dp_cmd), .rd_data(rd_data)
   );

   // A stalled response must hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Reads and writes never share a cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(dp_cmd.rd && dp_cmd.wr))
      else $error("read and write in one cycle");

   // An error response never carries data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> rsp_data.read_data == 8'h00)
      else $error("error response with data");

endmodule

// File: tb/pnrre_checker.sv
// Checker for the packed nibble rectangle raster engine: predicts each response beat
// from a private copy of the frame store and compares it with the engine's output.
// Depends on pnrre_pkg.
`timescale 1ns / 1ps

module pnrre_checker
   import pnrre_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  rsp_type rsp_data,
   output int fail_count,
   output int pending
);

   logic [7:0] frame_copy [0:RowBytes*RowCount-1];
   rsp_type expected_rsp [$];

   assign pending = expected_rsp.size();

   initial begin
      fail_count = 0;
      foreach (frame_copy[i]) frame_copy[i] = 8'h00;
   end

   task automatic nib_or(input int x, input int y, input logic [7:0] v);
      int i;
      i = y * RowBytes + x / 2;
      frame_copy[i] = frame_copy[i] | v;
   endtask

   task automatic nib_and(input int x, input int y, input logic [7:0] m);
      int i;
      i = y * RowBytes + x / 2;
      frame_copy[i] = frame_copy[i] & m;
   endtask

   // Field widths keep every column below 2*RowBytes and every row below RowCount,
   // so only a reversed start and end can raise the error flag.
   task automatic draw_command(input req_type r, output rsp_type o);
      int xs, ys, xe, ye, x, y, side, last_even;
      logic [7:0] lo, hi;
      bit box_ok;
      xs = r.x_start;
      ys = r.y_start;
      xe = r.x_end;
      ye = r.y_end;
      lo = {4'h0, r.color};
      hi = {r.color, 4'h0};
      last_even = xe & ~1;
      box_ok = (xs <= xe) && (ys <= ye);
      o = '0;
      case (cmd_type'(r.cmd))
         CMD_POINT: nib_or(xs, ys, (xs & 1) ? lo : hi);
         CMD_OUTLINE: begin
            if (!box_ok) o.error = 1'b1;
            else begin
               for (side = 0; side < 2; side++) begin
                  y = side ? ye : ys;
                  x = xs;
                  if (x & 1) begin
                     nib_or(x, y, lo);
                     x++;
                  end
                  while (x < last_even) begin
                     nib_or(x, y, lo | hi);
                     x += 2;
                  end
                  if (x < xe) nib_or(x, y, hi);
               end
               for (y = ys; y <= ye; y++) begin
                  nib_or(xs, y, (xs & 1) ? lo : hi);
                  nib_or(xe, y, (xe & 1) ? lo : hi);
               end
            end
         end
         CMD_CLR_OUTLINE: begin
            if (!box_ok) o.error = 1'b1;
            else begin
               for (side = 0; side < 2; side++) begin
                  y = side ? ye : ys;
                  x = xs;
                  if (x & 1) begin
                     nib_and(x, y, 8'hF0);
                     x++;
                  end
                  while (x < last_even) begin
                     nib_and(x, y, 8'h00);
                     x += 2;
                  end
                  // An odd right edge leaves the pixel left of it on the top and bottom.
                  if (!(xe & 1)) nib_and(x, y, 8'h0F);
               end
               for (y = ys; y <= ye; y++) begin
                  nib_and(xs, y, (xs & 1) ? 8'hF0 : 8'h0F);
                  nib_and(xe, y, (xe & 1) ? 8'hF0 : 8'h0F);
               end
            end
         end
         CMD_CLR_FILL: begin
            if (!box_ok) o.error = 1'b1;
            else begin
               for (y = ys; y <= ye; y++) begin
                  x = xs;
                  if (x & 1) begin
                     nib_and(x, y, 8'hF0);
                     x++;
                  end
                  while (x < xe) begin
                     nib_and(x, y, 8'h00);
                     x += 2;
                  end
                  if (!(xe & 1)) nib_and(xe, y, 8'h0F);
               end
            end
         end
         CMD_DOTTED: begin
            if (xs > xe) o.error = 1'b1;
            else begin
               for (x = xs; x < xe; x += 2) begin
                  nib_and(x, ys, 8'hF0);
                  nib_or(x, ys, hi);
               end
            end
         end
         CMD_CLR_ROWS: begin
            if (ys > ye) o.error = 1'b1;
            else begin
               for (y = ys; y <= ye; y++)
                  for (x = 0; x < RowBytes; x++) frame_copy[y * RowBytes + x] = 8'h00;
            end
         end
         CMD_READ: o.read_data = frame_copy[ys * RowBytes + xs / 2];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_rsp.delete();
      end else begin
         if (req_valid && !req_stall) begin
            draw_command(req_data, want);
            expected_rsp.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("response beat with no command waiting: read_data %0h error %0b",
                      rsp_data.read_data, rsp_data.error);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.read_data !== want.read_data) begin
                  $error("read_data expected %0h actual %0h", want.read_data,
                         rsp_data.read_data);
                  fail_count++;
               end
               if (rsp_data.error !== want.error) begin
                  $error("error expected %0b actual %0b", want.error, rsp_data.error);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// File: tb/tb_top.sv
// Top of the testbench for the packed nibble rectangle raster engine.
// Makes command beats and response stalls and gives the verdict; depends on
// pnrre_pkg, pnrre_checker and the engine's RTL.
`timescale 1ns / 1ps

module tb_top;
   import pnrre_pkg::*;

   localparam int RandomBeats = 750;
   localparam int QuietTail = 100;
   // Longest correct stretch without a beat is a clear of sixteen rows plus a receiver
   // stall; this is several times that.
   localparam int IdleLimit = 100000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   int fail_count;
   int pending;
   bit quiet;
   int idle_cycles;
   int stall_left;

   // Rows that a clear-rows command has zeroed. The frame store has no reset value,
   // so reads are aimed only at these rows; drawing keeps their bytes defined.
   bit clean_row [0:RowCount-1];

   packed_nibble_rectangle_raster_engine_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   pnrre_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls in random bursts until the quiet tail.
   initial begin
      rsp_stall = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (!quiet && $urandom_range(7) == 0) begin
            stall_left = $urandom_range(5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // The watchdog counts cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic req_type make_cmd(cmd_type c, int xs, int ys, int xe, int ye,
                                        int color);
      req_type r;
      r.cmd = c;
      r.x_start = 10'(xs);
      r.y_start = 9'(ys);
      r.x_end = 10'(xe);
      r.y_end = 9'(ye);
      r.color = 4'(color);
      return r;
   endfunction

   function automatic int some_clean_row();
      int y;
      y = $urandom_range(RowCount - 1);
      while (!clean_row[y]) y = $urandom_range(RowCount - 1);
      return y;
   endfunction

   // Sends one command beat, starting at a rising edge and returning at the edge that
   // accepts it. Stall is stable between edges, so it is looked at on the falling edge.
   task automatic send_beat(input req_type r);
      bit taken;
      int y;
      if (!quiet && $urandom_range(5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      if (r.cmd == CMD_CLR_ROWS && r.y_start <= r.y_end)
         for (y = r.y_start; y <= r.y_end; y++) clean_row[y] = 1'b1;
      req_valid <= 1'b1;
      req_data <= r;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   // Random command: mostly small well-formed shapes, some on cleared rows so that
   // later reads see them, a few tall or wide ones, and some reversed noise.
   function automatic req_type random_cmd();
      req_type r;
      int xs, ys, xe, ye, w, h, t;
      cmd_type c;
      c = cmd_type'($urandom_range(7));
      xs = $urandom_range(1023);
      ys = ($urandom_range(1)) ? some_clean_row() : $urandom_range(RowCount - 1);
      w = ($urandom_range(4) == 0) ? $urandom_range(1023 - xs) : $urandom_range(40);
      xe = (xs + w > 1023) ? 1023 : xs + w;
      h = $urandom_range(7);
      if (c == CMD_OUTLINE && $urandom_range(19) == 0) h = $urandom_range(511);
      if (c == CMD_CLR_FILL && w > 64) h = $urandom_range(3);
      if (c == CMD_CLR_ROWS) h = $urandom_range(2);
      ye = (ys + h > RowCount - 1) ? RowCount - 1 : ys + h;
      if (c == CMD_READ) ys = some_clean_row();
      r = make_cmd(c, xs, ys, xe, ye, $urandom_range(15));
      if ($urandom_range(9) == 0 && c inside {CMD_OUTLINE, CMD_CLR_OUTLINE, CMD_CLR_FILL,
                                             CMD_DOTTED, CMD_CLR_ROWS}) begin
         // Reversed noise: both pairs are forced strictly reversed.
         xs = $urandom_range(1023);
         xe = $urandom_range(1023);
         ys = $urandom_range(511);
         ye = $urandom_range(511);
         if (xs < xe) begin t = xs; xs = xe; xe = t; end
         if (xs == xe) begin if (xs == 0) xs = 1; else xe = xs - 1; end
         if (ys < ye) begin t = ys; ys = ye; ye = t; end
         if (ys == ye) begin if (ys == 0) ys = 1; else ye = ys - 1; end
         r = make_cmd(c, xs, ys, xe, ye, $urandom_range(15));
      end
      return r;
   endfunction

   initial begin
      req_type directed [$];
      int n;
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      idle_cycles = 0;
      foreach (clean_row[i]) clean_row[i] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: clear the rows used for reads first, then every command with
      // edge parities, both column and row extremes, reversed boxes and the unused code.
      directed.push_back(make_cmd(CMD_CLR_ROWS, 0, 0, 0, 15, 0));
      directed.push_back(make_cmd(CMD_CLR_ROWS, 0, 500, 0, 511, 0));
      directed.push_back(make_cmd(CMD_POINT, 0, 0, 0, 0, 15));
      directed.push_back(make_cmd(CMD_POINT, 1, 0, 0, 0, 10));
      directed.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0));
      directed.push_back(make_cmd(CMD_POINT, 1023, 511, 1023, 511, 5));
      directed.push_back(make_cmd(CMD_READ, 1022, 511, 0, 0, 0));
      directed.push_back(make_cmd(CMD_OUTLINE, 3, 2, 10, 6, 7));
      directed.push_back(make_cmd(CMD_READ, 2, 2, 0, 0, 0));
      directed.push_back(make_cmd(CMD_OUTLINE, 4, 8, 9, 9, 3));
      directed.push_back(make_cmd(CMD_CLR_OUTLINE, 3, 2, 10, 6, 0));
      directed.push_back(make_cmd(CMD_CLR_OUTLINE, 4, 8, 9, 9, 0));
      directed.push_back(make_cmd(CMD_READ, 8, 8, 0, 0, 0));
      directed.push_back(make_cmd(CMD_CLR_FILL, 1, 10, 6, 12, 0));
      directed.push_back(make_cmd(CMD_READ, 0, 11, 0, 0, 0));
      directed.push_back(make_cmd(CMD_DOTTED, 1, 14, 20, 14, 9));
      directed.push_back(make_cmd(CMD_READ, 10, 14, 0, 0, 0));
      directed.push_back(make_cmd(CMD_DOTTED, 0, 15, 0, 15, 12));
      directed.push_back(make_cmd(CMD_OUTLINE, 9, 3, 8, 4, 1));
      directed.push_back(make_cmd(CMD_CLR_ROWS, 0, 7, 0, 6, 0));
      directed.push_back(make_cmd(CMD_NONE, 1023, 511, 1023, 511, 15));
      directed.push_back(make_cmd(CMD_OUTLINE, 0, 0, 1023, 511, 1));
      directed.push_back(make_cmd(CMD_READ, 1023, 511, 0, 0, 0));
      directed.push_back(make_cmd(CMD_READ, 511, 0, 0, 0, 0));
      foreach (directed[i]) send_beat(directed[i]);

      for (n = 0; n < RandomBeats; n++) begin
         if (n == RandomBeats / 2) begin
            // Hold off until every response of the commands so far has come back. The
            // count is looked at on the falling edge, after the checker has seen the
            // beat accepted at the last rising edge.
            req_valid <= 1'b0;
            @(negedge clock);
            while (pending != 0) @(negedge clock);
            @(posedge clock);
         end
         if (n == RandomBeats - QuietTail) quiet = 1'b1;
         send_beat(random_cmd());
      end
      req_valid <= 1'b0;

      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
